/* sv/sca_pkg.sv */
// Shared types and constants for the scatter accumulate and average block.
// No dependencies; used by every other file of the block except sca_ram.
`default_nettype none

package sca_pkg;

  localparam int VALUE_W       = 32;
  localparam int IDX_W         = 12;
  localparam int CNT_W         = 8;
  localparam int SUM_W         = VALUE_W + CNT_W;
  localparam int LANES         = 6;
  localparam int PARTICLES_DEF = 4096;
  // widest index any legal store size can need, plus one for the range test
  localparam int IDX_EXT_W     = 17;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                       op;
    logic [IDX_W-1:0]          particle_index;
    logic                      member_present;
    logic                      cluster_used;
    logic signed [VALUE_W-1:0] pos_x;
    logic signed [VALUE_W-1:0] pos_y;
    logic signed [VALUE_W-1:0] pos_z;
    logic signed [VALUE_W-1:0] vel_x;
    logic signed [VALUE_W-1:0] vel_y;
    logic signed [VALUE_W-1:0] vel_z;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]          out_index;
    logic                      has_value;
    logic [CNT_W-1:0]          hit_count;
    logic signed [VALUE_W-1:0] avg_pos_x;
    logic signed [VALUE_W-1:0] avg_pos_y;
    logic signed [VALUE_W-1:0] avg_pos_z;
    logic signed [VALUE_W-1:0] avg_vel_x;
    logic signed [VALUE_W-1:0] avg_vel_y;
    logic signed [VALUE_W-1:0] avg_vel_z;
  } out_word_t;

  typedef logic [LANES-1:0][SUM_W-1:0]   sums_t;
  typedef logic [LANES-1:0][VALUE_W-1:0] vals_t;

  // one store entry: hit count and the six running sums
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    sums_t            sums;
  } mem_word_t;

endpackage

`default_nettype wire

/* sv/sca_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module sca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/sca_div.sv */
// Six-lane radix-2 restoring divider: signed sums over an unsigned count.
// Depends on sca_pkg; one quotient bit per lane per cycle, truncating toward zero.
`default_nettype none

module sca_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire sca_pkg::sums_t            dividend,
  input  wire logic [sca_pkg::CNT_W-1:0] divisor,
  output logic                           busy,
  output logic                           done,
  output sca_pkg::vals_t                 quotient
);

  localparam int STEP_W = $clog2(sca_pkg::SUM_W);

  sca_pkg::sums_t                                mag;
  sca_pkg::sums_t                                mag_next;
  logic [sca_pkg::LANES-1:0][sca_pkg::CNT_W-1:0] rem;
  logic [sca_pkg::LANES-1:0][sca_pkg::CNT_W-1:0] rem_next;
  logic [sca_pkg::LANES-1:0]                     neg;
  logic [sca_pkg::CNT_W-1:0]                     dsr;
  logic [STEP_W-1:0]                             step;

  // one restoring step on every lane
  always_comb begin
    logic [sca_pkg::CNT_W:0] sh;
    for (int i = 0; i < sca_pkg::LANES; i++) begin
      sh = {rem[i], mag[i][sca_pkg::SUM_W-1]};
      if (sh >= {1'b0, dsr}) begin
        rem_next[i] = sca_pkg::CNT_W'(sh - {1'b0, dsr});
        mag_next[i] = {mag[i][sca_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_next[i] = sh[sca_pkg::CNT_W-1:0];
        mag_next[i] = {mag[i][sca_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  // restore sign and narrow to the value width
  always_comb begin
    logic [sca_pkg::SUM_W-1:0] q;
    for (int i = 0; i < sca_pkg::LANES; i++) begin
      q = neg[i] ? (~mag[i] + 1'b1) : mag[i];
      quotient[i] = q[sca_pkg::VALUE_W-1:0];
    end
  end

  // load magnitudes, then iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(sca_pkg::SUM_W - 1);
        dsr  <= divisor;
        for (int i = 0; i < sca_pkg::LANES; i++) begin
          neg[i] <= dividend[i][sca_pkg::SUM_W-1];
          mag[i] <= dividend[i][sca_pkg::SUM_W-1] ? (~dividend[i] + 1'b1) : dividend[i];
          rem[i] <= '0;
        end
      end else if (busy) begin
        mag  <= mag_next;
        rem  <= rem_next;
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/scatter_accumulate_average.sv */
// Top level: per-particle sum store with read-modify-write update and averaging.
// Depends on sca_pkg, sca_ram and sca_div.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------
//  item     | item_valid / item_ready    | item   (sca_pkg::in_word_t)
//  result   | result_valid / result_ready| result (sca_pkg::out_word_t)
//
// Accumulate: store read, then add and write back on the one RAM.
// Read: store read, then the bit-serial divider; an empty entry skips the
// divider, and an out-of-range index goes straight to the output register.
// Clear, and reset, run a sweep writing zero to every entry; no word is taken
// meanwhile.
// A finished result waits in the output register while the next word is taken.
`default_nettype none

module scatter_accumulate_average #(
  parameter int PARTICLES = sca_pkg::PARTICLES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire sca_pkg::in_word_t  item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output sca_pkg::out_word_t      result
);

  localparam int AW = $clog2(PARTICLES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PARTICLES - 1);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_RMW,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                       state;
  logic [AW-1:0]                sweep_addr;
  logic [AW-1:0]                cur_addr;
  sca_pkg::in_word_t            cur;
  logic                         rd_zero;
  logic [sca_pkg::CNT_W-1:0]    rd_count;

  logic [sca_pkg::IDX_EXT_W-1:0] idx_ext;
  logic                          idx_ok;
  logic                          accept;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  sca_pkg::mem_word_t           ram_wdata;
  sca_pkg::mem_word_t           ram_rdata;
  sca_pkg::vals_t               cur_vals;

  logic                         div_start;
  logic                         div_busy;
  logic                         div_done;
  sca_pkg::vals_t               div_q;

  // index range test
  assign idx_ext    = sca_pkg::IDX_EXT_W'(item.particle_index);
  assign idx_ok     = idx_ext < sca_pkg::IDX_EXT_W'(PARTICLES);
  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;

  assign cur_vals = {cur.vel_z, cur.vel_y, cur.vel_x, cur.pos_z, cur.pos_y, cur.pos_x};

  // store write: sweep zeros, or write back the updated entry unless its count is saturated
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = '0;
    case (state)
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
      end
      ST_RMW: begin
        ram_we        = (ram_rdata.cnt != sca_pkg::COUNT_MAX);
        ram_wdata.cnt = ram_rdata.cnt + 1'b1;
        for (int i = 0; i < sca_pkg::LANES; i++) begin
          ram_wdata.sums[i] = ram_rdata.sums[i] +
                              {{sca_pkg::CNT_W{cur_vals[i][sca_pkg::VALUE_W-1]}}, cur_vals[i]};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  sca_ram #(
    .WIDTH ($bits(sca_pkg::mem_word_t)),
    .DEPTH (PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign div_start = (state == ST_LOAD) && (ram_rdata.cnt != '0);

  sca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ram_rdata.sums),
    .divisor  (ram_rdata.cnt),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SWEEP;
      sweep_addr   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != ST_EMIT) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == LAST_ADDR) begin
            sweep_addr <= '0;
            state      <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cur      <= item;
            cur_addr <= idx_ext[AW-1:0];
            case (item.op)
              sca_pkg::OP_CLEAR: begin
                state <= ST_SWEEP;
              end
              sca_pkg::OP_ACCUM: begin
                if (item.member_present && item.cluster_used && idx_ok) begin
                  state <= ST_RMW;
                end
              end
              sca_pkg::OP_READ: begin
                if (idx_ok) begin
                  state <= ST_LOAD;
                end else begin
                  rd_zero  <= 1'b1;
                  rd_count <= '0;
                  state    <= ST_EMIT;
                end
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_RMW: begin
          state <= ST_IDLE;
        end
        ST_LOAD: begin
          rd_count <= ram_rdata.cnt;
          rd_zero  <= (ram_rdata.cnt == '0);
          state    <= (ram_rdata.cnt == '0) ? ST_EMIT : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!result_valid || result_ready) begin
            result_valid     <= 1'b1;
            result.out_index <= cur.particle_index;
            result.has_value <= !rd_zero;
            result.hit_count <= rd_count;
            result.avg_pos_x <= rd_zero ? '0 : div_q[0];
            result.avg_pos_y <= rd_zero ? '0 : div_q[1];
            result.avg_pos_z <= rd_zero ? '0 : div_q[2];
            result.avg_vel_x <= rd_zero ? '0 : div_q[3];
            result.avg_vel_y <= rd_zero ? '0 : div_q[4];
            result.avg_vel_z <= rd_zero ? '0 : div_q[5];
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_SWEEP;
        end
      endcase
    end
  end

  // checks
  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !div_busy)
    else $error("word taken while divider busy");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_EMIT))
    else $error("result raised outside emit");

  a_flag_matches_count: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.has_value == (result.hit_count != '0)))
    else $error("has_value disagrees with hit_count");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

endmodule

`default_nettype wire

/* dv/tb.sv */
// Testbench for scatter_accumulate_average: directed table, saturation run, receiver
// hold-off, then random words, checked against an in-bench model of the per-particle sum store. Needs sca_pkg.
`default_nettype none

module tb;

  localparam int NPART    = 4096;
  localparam int N_RANDOM = 258;
  localparam int WD_LIMIT = 60000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  sca_pkg::in_word_t  item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  sca_pkg::out_word_t result;

  scatter_accumulate_average u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always #5 clk = ~clk;

  // model of the store
  logic signed [63:0]        acc_sum [NPART][sca_pkg::LANES];
  logic [sca_pkg::CNT_W-1:0] acc_cnt [NPART];
  sca_pkg::out_word_t        avg_q[$];

  int                 n_mismatch = 0;
  int                 wd_count = 0;
  bit                 idle_free = 1'b0;
  bit                 hold_rx = 1'b0;
  bit                 typed_pending = 1'b0;
  sca_pkg::out_word_t typed_exp = '0;

  function automatic logic signed [63:0] lane_in(sca_pkg::in_word_t w, int k);
    case (k)
      0: return 64'(w.pos_x);
      1: return 64'(w.pos_y);
      2: return 64'(w.pos_z);
      3: return 64'(w.vel_x);
      4: return 64'(w.vel_y);
      default: return 64'(w.vel_z);
    endcase
  endfunction

  task automatic clear_store();
    for (int i = 0; i < NPART; i++) begin
      acc_cnt[i] = '0;
      for (int k = 0; k < sca_pkg::LANES; k++) acc_sum[i][k] = '0;
    end
  endtask

  // apply one accepted word and queue any average it produces
  task automatic apply_word(sca_pkg::in_word_t w);
    sca_pkg::out_word_t r;
    logic signed [63:0] q [sca_pkg::LANES];
    int i;
    i = w.particle_index;
    case (w.op)
      sca_pkg::OP_CLEAR: clear_store();
      sca_pkg::OP_ACCUM: begin
        if (w.member_present && w.cluster_used && acc_cnt[i] != sca_pkg::COUNT_MAX) begin
          for (int k = 0; k < sca_pkg::LANES; k++) acc_sum[i][k] += lane_in(w, k);
          acc_cnt[i] += 1'b1;
        end
      end
      sca_pkg::OP_READ: begin
        r = '0;
        r.out_index = w.particle_index;
        r.hit_count = acc_cnt[i];
        r.has_value = acc_cnt[i] != 0;
        if (r.has_value) begin
          for (int k = 0; k < sca_pkg::LANES; k++) begin
            q[k] = acc_sum[i][k] / $signed({56'd0, acc_cnt[i]});
          end
          r.avg_pos_x = q[0][sca_pkg::VALUE_W-1:0];
          r.avg_pos_y = q[1][sca_pkg::VALUE_W-1:0];
          r.avg_pos_z = q[2][sca_pkg::VALUE_W-1:0];
          r.avg_vel_x = q[3][sca_pkg::VALUE_W-1:0];
          r.avg_vel_y = q[4][sca_pkg::VALUE_W-1:0];
          r.avg_vel_z = q[5][sca_pkg::VALUE_W-1:0];
        end
        avg_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_rx) result_ready <= 1'b0;
    else if (idle_free) result_ready <= 1'b1;
    else result_ready <= ($urandom_range(99) >= 15);
  end

  // check results and feed the model at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && item_ready) || (result_valid && result_ready)) wd_count <= 0;
      else wd_count <= wd_count + 1;
      if (item_valid && item_ready) begin
        apply_word(item);
        // a directed row with a typed value stands in for the model's entry
        if (typed_pending && item.op == sca_pkg::OP_READ) avg_q[$] = typed_exp;
      end
      if (result_valid && result_ready) begin
        if (avg_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result %p", result);
        end else if (avg_q[0] !== result) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p actual %p", avg_q[0], result);
          void'(avg_q.pop_front());
        end else begin
          void'(avg_q.pop_front());
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (wd_count >= WD_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // directed table: word plus, where obvious, the typed expected average
  typedef struct {
    sca_pkg::in_word_t  w;
    bit                 typed;
    sca_pkg::out_word_t exp_r;
  } row_t;
  row_t rows[$];

  function automatic sca_pkg::in_word_t mk(sca_pkg::op_e op, int idx, bit p, bit u,
                                           logic [31:0] v);
    sca_pkg::in_word_t w;
    w.op = op; w.particle_index = idx[sca_pkg::IDX_W-1:0];
    w.member_present = p; w.cluster_used = u;
    w.pos_x = v; w.pos_y = ~v; w.pos_z = v;
    w.vel_x = ~v; w.vel_y = v; w.vel_z = ~v;
    return w;
  endfunction

  function automatic sca_pkg::out_word_t mk_exp(int idx, int cnt, logic [31:0] v);
    sca_pkg::out_word_t r;
    r = '0;
    r.out_index = idx[sca_pkg::IDX_W-1:0];
    r.hit_count = cnt[sca_pkg::CNT_W-1:0];
    r.has_value = cnt != 0;
    if (cnt != 0) begin
      r.avg_pos_x = v; r.avg_pos_y = ~v; r.avg_pos_z = v;
      r.avg_vel_x = ~v; r.avg_vel_y = v; r.avg_vel_z = ~v;
    end
    return r;
  endfunction

  task automatic add_row(sca_pkg::in_word_t w, bit typed, sca_pkg::out_word_t e);
    row_t r;
    r.w = w; r.typed = typed; r.exp_r = e;
    rows.push_back(r);
  endtask

  // offer one word, idling first at random; valid stays up for a following word
  task automatic send(sca_pkg::in_word_t w);
    if (!idle_free) begin
      while ($urandom_range(99) < 15) begin
        item_valid <= 1'b0;
        @(negedge clk);
      end
    end
    item <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic sca_pkg::in_word_t rand_word(int hot);
    sca_pkg::in_word_t w;
    int r;
    w = '0;
    r = $urandom_range(99);
    if (r < 2) w.op = sca_pkg::OP_CLEAR;
    else if (r < 62) w.op = sca_pkg::OP_ACCUM;
    else if (r < 97) w.op = sca_pkg::OP_READ;
    else w.op = sca_pkg::op_e'(2'd3);
    w.particle_index = ($urandom_range(3) != 0) ? sca_pkg::IDX_W'(hot + $urandom_range(3))
                                                : sca_pkg::IDX_W'($urandom);
    w.member_present = ($urandom_range(9) != 0);
    w.cluster_used = ($urandom_range(9) != 0);
    w.pos_x = $urandom; w.pos_y = $urandom; w.pos_z = $urandom;
    w.vel_x = $urandom; w.vel_y = $urandom; w.vel_z = $urandom;
    return w;
  endfunction

  initial begin
    sca_pkg::out_word_t z;
    int hot;
    z = '0;
    // reset state, extremes, skipped adds, unused op, clear
    add_row(mk(sca_pkg::OP_READ, 0, 0, 0, 0), 1, mk_exp(0, 0, 0));
    add_row(mk(sca_pkg::OP_READ, 4095, 0, 0, 0), 1, mk_exp(4095, 0, 0));
    add_row(mk(sca_pkg::OP_ACCUM, 4095, 1, 1, 32'h7fffffff), 0, z);
    add_row(mk(sca_pkg::OP_READ, 4095, 0, 0, 0), 1, mk_exp(4095, 1, 32'h7fffffff));
    add_row(mk(sca_pkg::OP_ACCUM, 4095, 1, 1, 32'h7fffffff), 0, z);
    add_row(mk(sca_pkg::OP_READ, 4095, 0, 0, 0), 1, mk_exp(4095, 2, 32'h7fffffff));
    add_row(mk(sca_pkg::OP_ACCUM, 0, 1, 1, 32'h80000000), 0, z);
    add_row(mk(sca_pkg::OP_ACCUM, 0, 0, 1, 32'h12345678), 0, z);
    add_row(mk(sca_pkg::OP_ACCUM, 0, 1, 0, 32'h12345678), 0, z);
    add_row(mk(sca_pkg::OP_ACCUM, 0, 0, 0, 32'h12345678), 0, z);
    add_row(mk(sca_pkg::op_e'(2'd3), 0, 1, 1, 32'hffffffff), 0, z);
    add_row(mk(sca_pkg::OP_READ, 0, 0, 0, 0), 1, mk_exp(0, 1, 32'h80000000));
    add_row(mk(sca_pkg::OP_ACCUM, 0, 1, 1, 32'h00000003), 0, z);
    add_row(mk(sca_pkg::OP_ACCUM, 0, 1, 1, 32'hffffffff), 0, z);
    add_row(mk(sca_pkg::OP_READ, 0, 0, 0, 0), 0, z);
    add_row(mk(sca_pkg::OP_ACCUM, 7, 1, 1, 32'hfffffffd), 0, z);
    add_row(mk(sca_pkg::OP_ACCUM, 7, 1, 1, 32'h00000001), 0, z);
    add_row(mk(sca_pkg::OP_READ, 7, 1, 1, 32'hffffffff), 0, z);
    add_row(mk(sca_pkg::OP_CLEAR, 0, 1, 1, 32'hffffffff), 0, z);
    add_row(mk(sca_pkg::OP_READ, 4095, 0, 0, 0), 1, mk_exp(4095, 0, 0));
    add_row(mk(sca_pkg::OP_READ, 0, 0, 0, 0), 1, mk_exp(0, 0, 0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words
    foreach (rows[i]) begin
      typed_pending = rows[i].typed;
      typed_exp     = rows[i].exp_r;
      send(rows[i].w);
    end
    typed_pending = 1'b0;

    // saturate one entry past 255 hits
    for (int n = 0; n < 258; n++) begin
      idle_free = (n < 120);
      send(mk(sca_pkg::OP_ACCUM, 9, 1, 1, 32'h00010000 + n));
    end
    send(mk(sca_pkg::OP_READ, 9, 0, 0, 0));

    // long receiver hold-off while words keep coming
    hold_rx = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_rx = 1'b0;
      end
      for (int n = 0; n < 12; n++) send(mk(sca_pkg::OP_READ, 4095 - n, 0, 0, 32'h0));
    join

    // random words over a few hot entries
    hot = $urandom_range(4000);
    for (int n = 0; n < N_RANDOM; n++) begin
      idle_free = (n >= 120 && n < 200);
      if (n % 100 == 99) hot = $urandom_range(4000);
      send(rand_word(hot));
    end
    item_valid <= 1'b0;
    idle_free = 1'b0;

    wait (avg_q.size() == 0);
    repeat (200) @(posedge clk);
    if (n_mismatch == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
sv/sca_pkg.sv
sv/sca_ram.sv
sv/sca_div.sv
sv/scatter_accumulate_average.sv
dv/tb.sv
